/* rtl/sfcd_pkg.sv */
`default_nettype none
package sfcd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned HUM_W   = 10;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;   // 26 payload bits padded to 4 bytes
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [15:0]      HUM_MAX  = 16'd1000;

  // frame byte positions
  localparam logic [POS_W-1:0] POS_HUM_HI  = 3'd2;
  localparam logic [POS_W-1:0] POS_HUM_LO  = 3'd3;
  localparam logic [POS_W-1:0] POS_TEMP_HI = 3'd4;
  localparam logic [POS_W-1:0] POS_TEMP_LO = 3'd5;
  localparam logic [POS_W-1:0] POS_CRC_LO  = 3'd6;
  localparam logic [POS_W-1:0] POS_CRC_HI  = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_CHECK    = 1'b1;

  typedef struct packed {
    logic [15:0]      humidity_raw;
    logic [15:0]      temperature_raw;
    logic [BYTE_W-1:0] crc_lo;
    logic [BYTE_W-1:0] crc_hi;
    logic [CRC_W-1:0] crc_calc;
    logic             block_enable;
    logic             crc_check_enable;
  } frame_t;

  typedef struct packed {
    logic                     crc_error;
    logic                     reading_valid;
    logic signed [TEMP_W-1:0] temperature_tenths;
    logic [HUM_W-1:0]         humidity_tenths;
  } result_t;

  // one byte of CRC-16 Modbus, LSB first
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                               input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/sfcd_result.sv */
`default_nettype none
module sfcd_result (
  input  sfcd_pkg::frame_t  frame,
  output sfcd_pkg::result_t res
);
  import sfcd_pkg::*;

  logic [CRC_W-1:0]  received;
  logic              mismatch;
  logic              valid;
  logic [14:0]       mag;
  logic [TEMP_W-1:0] temp;
  logic [HUM_W-1:0]  hum;

  always_comb begin
    received = {frame.crc_hi, frame.crc_lo};
    mismatch = received != frame.crc_calc;
    valid    = frame.block_enable && (!mismatch || !frame.crc_check_enable);
    mag      = frame.temperature_raw[14:0];
    // sign-magnitude to two's complement; negative zero folds to 0
    temp     = frame.temperature_raw[15] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
    hum      = (frame.humidity_raw > HUM_MAX) ? HUM_MAX[HUM_W-1:0]
                                              : frame.humidity_raw[HUM_W-1:0];

    res.reading_valid      = valid;
    res.crc_error          = frame.block_enable && mismatch;
    res.humidity_tenths    = valid ? hum : '0;
    res.temperature_tenths = valid ? temp : '0;
  end

endmodule
`default_nettype wire

/* rtl/sensor_frame_crc_decoder.sv */
`default_nettype none
// Channel  Dir  tdata (low bit up)                              tuser (low bit up)
// in_      in   [7:0] rx_byte                                   [0] frame_start
// out_     out  [9:0] humidity_tenths, [25:10] temperature,     [0] reading_valid,
//               [31:26] zero                                    [1] crc_error
// cfg_     in   index 0 block_enable, index 1 crc_check_enable; no read-back
//
// One byte per cycle while in_tready is high; CRC, field capture and result
// formatting sit before the output register, where byte 7's result is registered.
// The output register is backed by a one-entry skid; in_tready drops only while
// the skid holds a result. Reset (rst_n, synchronous) restarts the frame at byte 0.
module sensor_frame_crc_decoder (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [sfcd_pkg::BYTE_W-1:0]           in_tdata,   // [7:0] rx_byte
  input  wire                                   in_tuser,   // frame_start
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [sfcd_pkg::OUT_DATA_W-1:0]       out_tdata,  // hum, temp, pad
  output logic [sfcd_pkg::OUT_USER_W-1:0]       out_tuser,  // valid, crc_error
  input  wire                                   cfg_wr_en,
  input  wire  [sfcd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [sfcd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import sfcd_pkg::*;

  logic              block_enable_r, crc_check_enable_r;
  logic [POS_W-1:0]  pos_r, pos_nxt, pos_cur;
  logic [CRC_W-1:0]  crc_r, crc_nxt, crc_cur;
  logic [15:0]       hum_raw_r, hum_raw_nxt;
  logic [15:0]       temp_raw_r, temp_raw_nxt;
  logic [BYTE_W-1:0] crc_lo_r, crc_lo_nxt;
  logic              in_acc, res_vld;
  frame_t            frame;
  result_t           res;
  logic              out_valid_r, skid_valid_r;
  result_t           out_r, skid_r;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    pos_cur      = in_tuser ? '0 : pos_r;
    crc_cur      = in_tuser ? CRC_INIT : crc_r;
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    hum_raw_nxt  = hum_raw_r;
    temp_raw_nxt = temp_raw_r;
    crc_lo_nxt   = crc_lo_r;
    res_vld      = 1'b0;
    if (in_acc) begin
      pos_nxt = pos_cur + 3'd1;
      crc_nxt = crc_cur;
      if (pos_cur < POS_CRC_LO) crc_nxt = crc_feed(crc_cur, in_tdata);
      case (pos_cur)
        POS_HUM_HI:  hum_raw_nxt  = {in_tdata, hum_raw_r[7:0]};
        POS_HUM_LO:  hum_raw_nxt  = {hum_raw_r[15:8], in_tdata};
        POS_TEMP_HI: temp_raw_nxt = {in_tdata, temp_raw_r[7:0]};
        POS_TEMP_LO: temp_raw_nxt = {temp_raw_r[15:8], in_tdata};
        POS_CRC_LO:  crc_lo_nxt   = in_tdata;
        POS_CRC_HI: begin
          res_vld = 1'b1;
          crc_nxt = CRC_INIT;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    frame.humidity_raw     = hum_raw_r;
    frame.temperature_raw  = temp_raw_r;
    frame.crc_lo           = crc_lo_r;
    frame.crc_hi           = in_tdata;
    frame.crc_calc         = crc_cur;
    frame.block_enable     = block_enable_r;
    frame.crc_check_enable = crc_check_enable_r;
  end

  sfcd_result u_result (
    .frame (frame),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_enable_r     <= 1'b0;
      crc_check_enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BLOCK_ENABLE: block_enable_r     <= cfg_wdata[0];
        CFG_CRC_CHECK:    crc_check_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      crc_r      <= CRC_INIT;
      hum_raw_r  <= '0;
      temp_raw_r <= '0;
      crc_lo_r   <= '0;
    end else begin
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      hum_raw_r  <= hum_raw_nxt;
      temp_raw_r <= temp_raw_nxt;
      crc_lo_r   <= crc_lo_nxt;
    end
  end

  // output register with skid: a new result only arrives while the skid is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_vld;
      end
    end else if (res_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_vld) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.temperature_tenths, out_r.humidity_tenths};
  assign out_tuser  = {out_r.crc_error, out_r.reading_valid};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("invalid reading carries nonzero values");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && pos_cur == POS_CRC_HI) |=> (pos_r == '0 && crc_r == CRC_INIT))
    else $error("frame did not restart after the CRC high byte");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && !skid_valid_r) |=> out_valid_r)
    else $error("result lost");

endmodule
`default_nettype wire
